@@ rtl/sha384_hash_core_assert.svh @@
// assertion macros shared by the sha-384 hash core rtl
`ifndef SHA384_HASH_CORE_ASSERT_SVH
`define SHA384_HASH_CORE_ASSERT_SVH

// same-cycle implication
`define SHA384_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHA384_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sha384_pkg.sv @@
// types, constants and round functions of the sha-384 hash core
package sha384_pkg;

   localparam int unsigned WORD_W       = 64;
   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned HASH_WORDS   = 8;
   localparam int unsigned DIGEST_WORDS = 6;
   localparam int unsigned ROUNDS       = 80;
   localparam int unsigned REQ_TDATA_W  = 72;
   localparam int unsigned RSP_TDATA_W  = 72;
   localparam int unsigned LEN_W        = 61;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic push;
      logic step;
   } sched_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic init;
   } round_ctl_type;

   localparam word_type PAD_MARKER = 64'h8000_0000_0000_0000;

   function automatic word_type rotr(input word_type x, input int unsigned amt);
      return (x >> amt) | (x << (WORD_W - amt));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type init_value(input logic [2:0] idx);
      word_type val;
      unique case (idx)
         3'd0: val = 64'hcbbb9d5dc1059ed8;
         3'd1: val = 64'h629a292a367cd507;
         3'd2: val = 64'h9159015a3070dd17;
         3'd3: val = 64'h152fecd8f70e5939;
         3'd4: val = 64'h67332667ffc00b31;
         3'd5: val = 64'h8eb44a8768581511;
         3'd6: val = 64'hdb0c2e0d64f98fa7;
         3'd7: val = 64'h47b5481dbefa4fa4;
      endcase
      return val;
   endfunction

   function automatic word_type round_const(input logic [6:0] t);
      word_type val;
      unique case (t)
         7'd0:  val = 64'h428a2f98d728ae22;
         7'd1:  val = 64'h7137449123ef65cd;
         7'd2:  val = 64'hb5c0fbcfec4d3b2f;
         7'd3:  val = 64'he9b5dba58189dbbc;
         7'd4:  val = 64'h3956c25bf348b538;
         7'd5:  val = 64'h59f111f1b605d019;
         7'd6:  val = 64'h923f82a4af194f9b;
         7'd7:  val = 64'hab1c5ed5da6d8118;
         7'd8:  val = 64'hd807aa98a3030242;
         7'd9:  val = 64'h12835b0145706fbe;
         7'd10: val = 64'h243185be4ee4b28c;
         7'd11: val = 64'h550c7dc3d5ffb4e2;
         7'd12: val = 64'h72be5d74f27b896f;
         7'd13: val = 64'h80deb1fe3b1696b1;
         7'd14: val = 64'h9bdc06a725c71235;
         7'd15: val = 64'hc19bf174cf692694;
         7'd16: val = 64'he49b69c19ef14ad2;
         7'd17: val = 64'hefbe4786384f25e3;
         7'd18: val = 64'h0fc19dc68b8cd5b5;
         7'd19: val = 64'h240ca1cc77ac9c65;
         7'd20: val = 64'h2de92c6f592b0275;
         7'd21: val = 64'h4a7484aa6ea6e483;
         7'd22: val = 64'h5cb0a9dcbd41fbd4;
         7'd23: val = 64'h76f988da831153b5;
         7'd24: val = 64'h983e5152ee66dfab;
         7'd25: val = 64'ha831c66d2db43210;
         7'd26: val = 64'hb00327c898fb213f;
         7'd27: val = 64'hbf597fc7beef0ee4;
         7'd28: val = 64'hc6e00bf33da88fc2;
         7'd29: val = 64'hd5a79147930aa725;
         7'd30: val = 64'h06ca6351e003826f;
         7'd31: val = 64'h142929670a0e6e70;
         7'd32: val = 64'h27b70a8546d22ffc;
         7'd33: val = 64'h2e1b21385c26c926;
         7'd34: val = 64'h4d2c6dfc5ac42aed;
         7'd35: val = 64'h53380d139d95b3df;
         7'd36: val = 64'h650a73548baf63de;
         7'd37: val = 64'h766a0abb3c77b2a8;
         7'd38: val = 64'h81c2c92e47edaee6;
         7'd39: val = 64'h92722c851482353b;
         7'd40: val = 64'ha2bfe8a14cf10364;
         7'd41: val = 64'ha81a664bbc423001;
         7'd42: val = 64'hc24b8b70d0f89791;
         7'd43: val = 64'hc76c51a30654be30;
         7'd44: val = 64'hd192e819d6ef5218;
         7'd45: val = 64'hd69906245565a910;
         7'd46: val = 64'hf40e35855771202a;
         7'd47: val = 64'h106aa07032bbd1b8;
         7'd48: val = 64'h19a4c116b8d2d0c8;
         7'd49: val = 64'h1e376c085141ab53;
         7'd50: val = 64'h2748774cdf8eeb99;
         7'd51: val = 64'h34b0bcb5e19b48a8;
         7'd52: val = 64'h391c0cb3c5c95a63;
         7'd53: val = 64'h4ed8aa4ae3418acb;
         7'd54: val = 64'h5b9cca4f7763e373;
         7'd55: val = 64'h682e6ff3d6b2b8a3;
         7'd56: val = 64'h748f82ee5defb2fc;
         7'd57: val = 64'h78a5636f43172f60;
         7'd58: val = 64'h84c87814a1f0ab72;
         7'd59: val = 64'h8cc702081a6439ec;
         7'd60: val = 64'h90befffa23631e28;
         7'd61: val = 64'ha4506cebde82bde9;
         7'd62: val = 64'hbef9a3f7b2c67915;
         7'd63: val = 64'hc67178f2e372532b;
         7'd64: val = 64'hca273eceea26619c;
         7'd65: val = 64'hd186b8c721c0c207;
         7'd66: val = 64'heada7dd6cde0eb1e;
         7'd67: val = 64'hf57d4f7fee6ed178;
         7'd68: val = 64'h06f067aa72176fba;
         7'd69: val = 64'h0a637dc5a2c898a6;
         7'd70: val = 64'h113f9804bef90dae;
         7'd71: val = 64'h1b710b35131c471b;
         7'd72: val = 64'h28db77f523047d84;
         7'd73: val = 64'h32caab7b40c72493;
         7'd74: val = 64'h3c9ebe0a15c9bebc;
         7'd75: val = 64'h431d67c49c100d4c;
         7'd76: val = 64'h4cc5d4becb3e42b6;
         7'd77: val = 64'h597f299cfc657e2a;
         7'd78: val = 64'h5fcb6fab3ad6faec;
         7'd79: val = 64'h6c44198c4a475817;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/sha384_sched.sv @@
// block buffer and rolling message schedule, one word shifted in per cycle while push or step is set
module sha384_sched (
   input  logic                     clock,
   input  sha384_pkg::sched_ctl_type ctl,
   input  sha384_pkg::word_type     push_word,
   output sha384_pkg::word_type     cur_word
);
   import sha384_pkg::*;

   word_type win_ff [BLOCK_WORDS];
   word_type win_in [BLOCK_WORDS];
   word_type next_w;
   word_type shift_w;

   always_comb begin
      next_w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      shift_w = ctl.push ? push_word : next_w;
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[BLOCK_WORDS - 1] = shift_w;
   end

   always_ff @(posedge clock) begin
      if (ctl.push || ctl.step) begin
         win_ff <= win_in;
      end
   end

   assign cur_word = win_ff[0];

endmodule

@@ rtl/sha384_round.sv @@
// working variables, round datapath and chaining value
module sha384_round (
   input  logic                     clock,
   input  logic                     reset,
   input  sha384_pkg::round_ctl_type ctl,
   input  logic [6:0]               round_idx,
   input  sha384_pkg::word_type     sched_word,
   input  logic [2:0]               out_idx,
   output sha384_pkg::word_type     digest_word
);
   import sha384_pkg::*;

   word_type cv_ff [HASH_WORDS];
   word_type cv_in [HASH_WORDS];
   word_type v_ff  [HASH_WORDS];
   word_type v_in  [HASH_WORDS];
   word_type t1;
   word_type t2;

   always_comb begin
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + round_const(round_idx) + sched_word;
      t2 = big_sigma0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      v_in = v_ff;
      if (ctl.load) begin
         v_in = cv_ff;
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_comb begin
      for (int i = 0; i < HASH_WORDS; i++) begin
         priority if (ctl.init) begin
            cv_in[i] = init_value(3'(i));
         end else if (ctl.fold) begin
            cv_in[i] = cv_ff[i] + v_ff[i];
         end else begin
            cv_in[i] = cv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            cv_ff[i] <= init_value(3'(i));
         end
      end else begin
         cv_ff <= cv_in;
      end
   end

   assign digest_word = cv_ff[out_idx];

endmodule

@@ rtl/sha384_hash_core.sv @@
// sha-384 hash core top level: word intake, padding sequencer and digest output
//
//  channel  dir  handshake                  payload
//  req_     in   req_tvalid / req_tready    tdata data_word, byte_count; tlast last
//  rsp_     out  rsp_tvalid / rsp_tready    tdata digest_word, word_index; tlast last_word
//
//  a word that does not complete a block is only stored in the buffer; one that does starts
//  the 80 rounds on the single round unit, then a fold into the chain
//  the final word is followed by the padding words, one per cycle, and one or two block runs,
//  then six digest transactions, one per cycle while rsp_tready is high
//  reset is synchronous and returns the chaining value to the initial hash
//  req_tready is high only in idle: low through padding, rounds, fold and digest output
module sha384_hash_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [63:0] data_word, [67:64] byte_count, [71:68] zero
   input  logic [sha384_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [63:0] digest_word, [66:64] word_index, [71:67] zero
   output logic [sha384_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import sha384_pkg::*;

   `include "sha384_hash_core_assert.svh"

   localparam logic [3:0] FILL_LAST  = 4'(BLOCK_WORDS - 1);
   localparam logic [3:0] FILL_EXTRA = 4'(BLOCK_WORDS - 2);
   localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
   localparam logic [2:0] IDX_LAST   = 3'(DIGEST_WORDS - 1);
   localparam logic [3:0] FULL_COUNT = 4'd8;

   state_type       state_ff, state_in;
   logic [3:0]      fill_ff, fill_in;
   logic [6:0]      round_ff, round_in;
   logic [2:0]      idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic            fin_ff, fin_in;
   logic            mark_ff, mark_in;
   logic            extra_ff, extra_in;
   logic            done_ff, done_in;

   sched_ctl_type   sched_ctl;
   round_ctl_type   round_ctl;
   word_type        push_word;
   word_type        cur_word;
   word_type        digest_word;
   word_type        data_word;
   word_type        keep_mask;
   word_type        marker_word;
   word_type        len_word;
   logic [3:0]      byte_count;
   logic [3:0]      cnt_eff;
   logic [5:0]      shamt;
   logic            accept;
   logic            out_accept;
   logic            push;
   logic            full;
   logic            mark_push;

   assign data_word  = req_tdata[63:0];
   assign byte_count = req_tdata[67:64];
   assign accept     = req_tvalid && req_tready;
   assign out_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      if (!req_tlast || byte_count > FULL_COUNT) begin
         cnt_eff = FULL_COUNT;
      end else begin
         cnt_eff = byte_count;
      end
      shamt       = {cnt_eff[2:0], 3'b000};
      keep_mask   = ~({WORD_W{1'b1}} >> shamt);
      marker_word = PAD_MARKER >> shamt;
      len_word    = {len_ff, 3'b000};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (fill_ff == FILL_LAST) begin
                  state_in = ST_ROUND;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROUND: begin
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            priority if (done_ff) begin
               state_in = ST_OUT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (fill_ff == FILL_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (rsp_tready && idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      push       = accept || (state_ff == ST_PAD);
      full       = push && (fill_ff == FILL_LAST);
      mark_push  = (accept && req_tlast && cnt_eff != FULL_COUNT)
                   || (state_ff == ST_PAD && mark_ff);

      priority if (accept) begin
         if (req_tlast && cnt_eff != FULL_COUNT) begin
            push_word = (data_word & keep_mask) | marker_word;
         end else begin
            push_word = data_word;
         end
      end else if (mark_ff) begin
         push_word = PAD_MARKER;
      end else if (fill_ff == FILL_LAST && !extra_ff) begin
         push_word = len_word;
      end else begin
         push_word = '0;
      end

      sched_ctl.push = push;
      sched_ctl.step = (state_ff == ST_ROUND);
      round_ctl.load = full;
      round_ctl.step = (state_ff == ST_ROUND);
      round_ctl.fold = (state_ff == ST_FOLD);
      round_ctl.init = out_accept && (idx_ff == IDX_LAST);

      fill_in  = push ? fill_ff + 4'd1 : fill_ff;
      round_in = (state_ff == ST_ROUND && round_ff != ROUND_LAST) ? round_ff + 7'd1 : '0;

      idx_in = idx_ff;
      if (out_accept) begin
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 3'd1;
      end

      len_in = len_ff;
      if (accept) begin
         len_in = len_ff + LEN_W'(cnt_eff);
      end else if (round_ctl.init) begin
         len_in = '0;
      end

      fin_in = fin_ff;
      if (accept && req_tlast) begin
         fin_in = 1'b1;
      end else if (round_ctl.init) begin
         fin_in = 1'b0;
      end

      mark_in = mark_ff;
      if (accept && req_tlast && cnt_eff == FULL_COUNT) begin
         mark_in = 1'b1;
      end else if (state_ff == ST_PAD) begin
         mark_in = 1'b0;
      end

      extra_in = extra_ff;
      if (mark_push && fill_ff == FILL_EXTRA) begin
         extra_in = 1'b1;
      end else if (state_ff == ST_PAD && !mark_ff && fill_ff == FILL_LAST) begin
         extra_in = 1'b0;
      end

      done_in = done_ff;
      if (state_ff == ST_PAD && !mark_ff && fill_ff == FILL_LAST && !extra_ff) begin
         done_in = 1'b1;
      end else if (round_ctl.init) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         len_ff   <= '0;
         fin_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         extra_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
         mark_ff  <= mark_in;
         extra_ff <= extra_in;
         done_ff  <= done_in;
      end
   end

   sha384_sched u_sched (
      .clock     (clock),
      .ctl       (sched_ctl),
      .push_word (push_word),
      .cur_word  (cur_word)
   );

   sha384_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (round_ctl),
      .round_idx   (round_ff),
      .sched_word  (cur_word),
      .out_idx     (idx_ff),
      .digest_word (digest_word)
   );

   assign rsp_tdata = {5'b00000, idx_ff, digest_word};
   assign rsp_tlast = (idx_ff == IDX_LAST);

   `SHA384_ASSERT_IMP(a_no_intake_during_output, clock, reset, rsp_tvalid, !req_tready, "intake open while digest pending")
   `SHA384_ASSERT_IMP(a_round_in_range, clock, reset, state_ff == ST_ROUND, round_ff <= ROUND_LAST, "round index out of range")
   `SHA384_ASSERT_NXT(a_full_block_runs, clock, reset, accept && !req_tlast && fill_ff == FILL_LAST, state_ff == ST_ROUND, "full block did not start rounds")
   `SHA384_ASSERT_NXT(a_digest_end_clears, clock, reset, out_accept && rsp_tlast, state_ff == ST_IDLE && len_ff == '0 && !fin_ff, "message state not cleared after digest")
   `SHA384_ASSERT_IMP(a_output_aligned, clock, reset, state_ff == ST_OUT, fill_ff == '0 && done_ff && !mark_ff, "digest shown with partial block")

endmodule
